FILE: hw/rtl/cpmp_pkg.sv
package cpmp_pkg;

  // Field and datapath widths
  localparam int ENC_W      = 16;
  localparam int SPEED_W    = 17;
  localparam int VAL_W      = 32;
  localparam int DIFF_W     = 33;
  localparam int GAIN_W     = 20;
  localparam int PROD_W     = 53;
  localparam int ACC_W      = 55;
  localparam int FRAC_W     = 16;
  localparam int QUO_W      = ACC_W - FRAC_W;
  localparam int CMP_W      = 10;
  localparam int DRV_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Control constants
  localparam int DRIVE_LIMIT  = 1000;
  localparam int INTEGRAL_CAP = 100000;
  localparam int FAR_DISTANCE = 200000;
  localparam int FAR_SPEED    = 1298;
  localparam int WRAP_POINT   = 30000;
  localparam int Q_ROUND      = (1 << FRAC_W) - 1;

  // Gain reset values, signed Q3.16
  localparam logic signed [GAIN_W-1:0] SPEED_KP_RST    = 20'sd39322;
  localparam logic signed [GAIN_W-1:0] SPEED_KI_RST    = 20'sd328;
  localparam logic signed [GAIN_W-1:0] SPEED_KD_RST    = -20'sd26214;
  localparam logic signed [GAIN_W-1:0] POSITION_KP_RST = 20'sd328;
  localparam logic signed [GAIN_W-1:0] POSITION_KD_RST = -20'sd5243;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSITION_MODE   = 3'd0,
    REG_SPEED_TARGET    = 3'd1,
    REG_POSITION_TARGET = 3'd2,
    REG_SPEED_KP        = 3'd3,
    REG_SPEED_KI        = 3'd4,
    REG_SPEED_KD        = 3'd5,
    REG_POSITION_KP     = 3'd6,
    REG_POSITION_KD     = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_PKP  = 3'd1,
    MUL_PKD  = 3'd2,
    MUL_SKP  = 3'd3,
    MUL_SKI  = 3'd4,
    MUL_SKD  = 3'd5
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef struct packed {
    logic                     position_mode;
    logic signed [ENC_W-1:0]  speed_target;
    logic signed [GAIN_W-1:0] speed_kp;
    logic signed [GAIN_W-1:0] speed_ki;
    logic signed [GAIN_W-1:0] speed_kd;
    logic signed [GAIN_W-1:0] position_kp;
    logic signed [GAIN_W-1:0] position_kd;
  } cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     dist_upd;
    logic     goal_far;
    logic     goal_pd;
    logic     err_upd;
    logic     int_upd;
    logic     ld_upd;
    logic     lerr_upd;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     out_load;
  } cmd_t;

  // Saturate a wide signed value to the 32-bit signed range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [QUO_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v[QUO_W-1:VAL_W-1] == {(QUO_W-VAL_W+1){v[QUO_W-1]}}) begin
      r = v[VAL_W-1:0];
    end else if (v[QUO_W-1]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/cpmp_datapath.sv
module cpmp_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cpmp_pkg::cmd_t                         cmd,
  input  cpmp_pkg::cfg_t                         cfg,
  input  logic                                   dist_load,
  input  logic        [cpmp_pkg::CFG_DATA_W-1:0] dist_value,
  input  logic        [cpmp_pkg::ENC_W-1:0]      in_encoder_count,
  output logic                                   far,
  output logic        [cpmp_pkg::CMP_W-1:0]      out_compare_a,
  output logic        [cpmp_pkg::CMP_W-1:0]      out_compare_b,
  output logic signed [cpmp_pkg::DRV_W-1:0]      out_drive_value,
  output logic signed [cpmp_pkg::VAL_W-1:0]      out_speed_goal_used
);

  // Loop state
  logic signed [cpmp_pkg::VAL_W-1:0]   integ_r, integ_nxt;
  logic signed [cpmp_pkg::VAL_W-1:0]   lerr_r;
  logic signed [cpmp_pkg::VAL_W-1:0]   rd_r, rd_nxt;
  logic signed [cpmp_pkg::VAL_W-1:0]   ld_r;

  // Working registers
  logic signed [cpmp_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  logic signed [cpmp_pkg::VAL_W-1:0]   goal_r;
  logic signed [cpmp_pkg::VAL_W-1:0]   err_r, err_nxt;
  logic signed [cpmp_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [cpmp_pkg::ACC_W-1:0]   acc_r;

  logic signed [cpmp_pkg::VAL_W-1:0]   int_sum;
  logic signed [cpmp_pkg::GAIN_W-1:0]  mul_a;
  logic signed [cpmp_pkg::DIFF_W-1:0]  mul_b;
  logic signed [cpmp_pkg::ACC_W-1:0]   biased;
  logic signed [cpmp_pkg::QUO_W-1:0]   quo;
  logic signed [cpmp_pkg::VAL_W-1:0]   goal_pd;
  logic signed [cpmp_pkg::DRV_W-1:0]   drive;
  logic signed [cpmp_pkg::DRV_W-1:0]   cmp_a_full, cmp_b_full;

  // Raw count above the wrap point is count - 65536: just a set sign bit in 17 bits
  assign speed_nxt = (in_encoder_count > cpmp_pkg::ENC_W'(cpmp_pkg::WRAP_POINT)) ?
                     {1'b1, in_encoder_count} : {1'b0, in_encoder_count};

  assign rd_nxt = cpmp_pkg::sat32(cpmp_pkg::QUO_W'(cpmp_pkg::DIFF_W'(rd_r)
                                  - cpmp_pkg::DIFF_W'(speed_r)));
  assign far    = rd_r > cpmp_pkg::VAL_W'(cpmp_pkg::FAR_DISTANCE);

  assign err_nxt = cpmp_pkg::sat32(cpmp_pkg::QUO_W'(cpmp_pkg::DIFF_W'(goal_r)
                                   - cpmp_pkg::DIFF_W'(speed_r)));

  assign int_sum   = cpmp_pkg::sat32(cpmp_pkg::QUO_W'(cpmp_pkg::DIFF_W'(integ_r)
                                     + cpmp_pkg::DIFF_W'(err_r)));
  assign integ_nxt = (cfg.position_mode && int_sum > cpmp_pkg::VAL_W'(cpmp_pkg::INTEGRAL_CAP)) ?
                     cpmp_pkg::VAL_W'(cpmp_pkg::INTEGRAL_CAP) : int_sum;

  // Shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      cpmp_pkg::MUL_PKP: begin
        mul_a = cfg.position_kp;
        mul_b = cpmp_pkg::DIFF_W'(rd_r);
      end
      cpmp_pkg::MUL_PKD: begin
        mul_a = cfg.position_kd;
        mul_b = cpmp_pkg::DIFF_W'(rd_r) - cpmp_pkg::DIFF_W'(ld_r);
      end
      cpmp_pkg::MUL_SKP: begin
        mul_a = cfg.speed_kp;
        mul_b = cpmp_pkg::DIFF_W'(err_r);
      end
      cpmp_pkg::MUL_SKI: begin
        mul_a = cfg.speed_ki;
        mul_b = cpmp_pkg::DIFF_W'(integ_r);
      end
      cpmp_pkg::MUL_SKD: begin
        mul_a = cfg.speed_kd;
        mul_b = cpmp_pkg::DIFF_W'(err_r) - cpmp_pkg::DIFF_W'(lerr_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Truncate the Q.16 sum toward zero
  assign biased  = acc_r + (acc_r[cpmp_pkg::ACC_W-1] ?
                   cpmp_pkg::ACC_W'(cpmp_pkg::Q_ROUND) : cpmp_pkg::ACC_W'(0));
  assign quo     = biased[cpmp_pkg::ACC_W-1:cpmp_pkg::FRAC_W];
  assign goal_pd = cpmp_pkg::sat32(quo);

  always_comb begin
    if (quo > cpmp_pkg::QUO_W'(cpmp_pkg::DRIVE_LIMIT)) begin
      drive = cpmp_pkg::DRV_W'(cpmp_pkg::DRIVE_LIMIT);
    end else if (quo < -cpmp_pkg::QUO_W'(cpmp_pkg::DRIVE_LIMIT)) begin
      drive = -cpmp_pkg::DRV_W'(cpmp_pkg::DRIVE_LIMIT);
    end else begin
      drive = quo[cpmp_pkg::DRV_W-1:0];
    end
  end

  assign cmp_a_full = (drive > cpmp_pkg::DRV_W'(0)) ?
                      cpmp_pkg::DRV_W'(cpmp_pkg::DRIVE_LIMIT) - drive :
                      cpmp_pkg::DRV_W'(cpmp_pkg::DRIVE_LIMIT);
  assign cmp_b_full = (drive < cpmp_pkg::DRV_W'(0)) ?
                      cpmp_pkg::DRV_W'(cpmp_pkg::DRIVE_LIMIT) + drive :
                      cpmp_pkg::DRV_W'(cpmp_pkg::DRIVE_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      lerr_r  <= '0;
      rd_r    <= '0;
      ld_r    <= '0;
    end else begin
      if (cmd.int_upd) begin
        integ_r <= integ_nxt;
      end
      if (cmd.lerr_upd) begin
        lerr_r <= err_r;
      end
      if (dist_load) begin
        rd_r <= dist_value;
      end else if (cmd.dist_upd) begin
        rd_r <= rd_nxt;
      end
      if (cmd.ld_upd) begin
        ld_r <= rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load_in) begin
      speed_r <= speed_nxt;
      goal_r  <= cpmp_pkg::VAL_W'(cfg.speed_target);
    end else if (cmd.goal_far) begin
      goal_r <= cpmp_pkg::VAL_W'(cpmp_pkg::FAR_SPEED);
    end else if (cmd.goal_pd) begin
      goal_r <= goal_pd;
    end
    if (cmd.err_upd) begin
      err_r <= err_nxt;
    end
    case (cmd.acc_op)
      cpmp_pkg::ACC_LOAD: acc_r <= cpmp_pkg::ACC_W'(prod_r);
      cpmp_pkg::ACC_ADD:  acc_r <= acc_r + cpmp_pkg::ACC_W'(prod_r);
      default:            acc_r <= acc_r;
    endcase
    if (cmd.out_load) begin
      out_compare_a       <= cmp_a_full[cpmp_pkg::CMP_W-1:0];
      out_compare_b       <= cmp_b_full[cpmp_pkg::CMP_W-1:0];
      out_drive_value     <= drive;
      out_speed_goal_used <= goal_r;
    end
  end

endmodule

FILE: hw/rtl/cpmp_ctrl.sv
module cpmp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  input  logic           pos_mode,
  input  logic           far,
  output logic           in_ready,
  output logic           out_valid,
  output cpmp_pkg::cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DIST   = 12'b0000_0000_0010,
    S_PCHK   = 12'b0000_0000_0100,
    S_PMUL   = 12'b0000_0000_1000,
    S_PACC   = 12'b0000_0001_0000,
    S_PGOAL  = 12'b0000_0010_0000,
    S_ERR    = 12'b0000_0100_0000,
    S_INT    = 12'b0000_1000_0000,
    S_SMUL   = 12'b0001_0000_0000,
    S_SMUL2  = 12'b0010_0000_0000,
    S_SACC   = 12'b0100_0000_0000,
    S_FINISH = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = pos_mode ? S_DIST : S_ERR;
        end
      end
      S_DIST: begin
        cmd.dist_upd = 1'b1;
        state_nxt    = S_PCHK;
      end
      S_PCHK: begin
        cmd.mul_sel = cpmp_pkg::MUL_PKP;
        if (far) begin
          cmd.goal_far = 1'b1;
          state_nxt    = S_ERR;
        end else begin
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: begin
        cmd.mul_sel = cpmp_pkg::MUL_PKD;
        cmd.acc_op  = cpmp_pkg::ACC_LOAD;
        cmd.ld_upd  = 1'b1;
        state_nxt   = S_PACC;
      end
      S_PACC: begin
        cmd.acc_op = cpmp_pkg::ACC_ADD;
        state_nxt  = S_PGOAL;
      end
      S_PGOAL: begin
        cmd.goal_pd = 1'b1;
        state_nxt   = S_ERR;
      end
      S_ERR: begin
        cmd.err_upd = 1'b1;
        state_nxt   = S_INT;
      end
      S_INT: begin
        cmd.int_upd = 1'b1;
        cmd.mul_sel = cpmp_pkg::MUL_SKP;
        state_nxt   = S_SMUL;
      end
      S_SMUL: begin
        cmd.mul_sel = cpmp_pkg::MUL_SKI;
        cmd.acc_op  = cpmp_pkg::ACC_LOAD;
        state_nxt   = S_SMUL2;
      end
      S_SMUL2: begin
        cmd.mul_sel  = cpmp_pkg::MUL_SKD;
        cmd.acc_op   = cpmp_pkg::ACC_ADD;
        cmd.lerr_upd = 1'b1;
        state_nxt    = S_SACC;
      end
      S_SACC: begin
        cmd.acc_op = cpmp_pkg::ACC_ADD;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output slot is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/cascaded_pid_motor_pwm.sv
// Sequencing: a new input beat is accepted only once the previous one has been loaded
//   into the output register, since the single shared 20x33 multiplier is taken in
//   turns by the speed PID and the position PD.
// Reset: synchronous, active low; clears the integral, last-error and distance state and
//   restores the gains, mode and speed target to their power-on values.
module cascaded_pid_motor_pwm (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel: one control tick per beat
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [cpmp_pkg::ENC_W-1:0]      in_encoder_count,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [cpmp_pkg::CMP_W-1:0]      out_compare_a,
  output logic        [cpmp_pkg::CMP_W-1:0]      out_compare_b,
  output logic signed [cpmp_pkg::DRV_W-1:0]      out_drive_value,
  output logic signed [cpmp_pkg::VAL_W-1:0]      out_speed_goal_used,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic        [cpmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [cpmp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  cpmp_pkg::cfg_t cfg_r, cfg_nxt;
  cpmp_pkg::cmd_t cmd;
  logic           far;
  logic           dist_load;

  // Register file. A write to the position target does not keep a copy here:
  // it goes straight into the remaining distance held by the datapath.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        cpmp_pkg::REG_POSITION_MODE: cfg_nxt.position_mode = cfg_wdata[0];
        cpmp_pkg::REG_SPEED_TARGET:  cfg_nxt.speed_target  = cfg_wdata[cpmp_pkg::ENC_W-1:0];
        cpmp_pkg::REG_SPEED_KP:      cfg_nxt.speed_kp      = cfg_wdata[cpmp_pkg::GAIN_W-1:0];
        cpmp_pkg::REG_SPEED_KI:      cfg_nxt.speed_ki      = cfg_wdata[cpmp_pkg::GAIN_W-1:0];
        cpmp_pkg::REG_SPEED_KD:      cfg_nxt.speed_kd      = cfg_wdata[cpmp_pkg::GAIN_W-1:0];
        cpmp_pkg::REG_POSITION_KP:   cfg_nxt.position_kp   = cfg_wdata[cpmp_pkg::GAIN_W-1:0];
        cpmp_pkg::REG_POSITION_KD:   cfg_nxt.position_kd   = cfg_wdata[cpmp_pkg::GAIN_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  assign dist_load = cfg_we && (cfg_index == cpmp_pkg::REG_POSITION_TARGET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.position_mode <= 1'b0;
      cfg_r.speed_target  <= '0;
      cfg_r.speed_kp      <= cpmp_pkg::SPEED_KP_RST;
      cfg_r.speed_ki      <= cpmp_pkg::SPEED_KI_RST;
      cfg_r.speed_kd      <= cpmp_pkg::SPEED_KD_RST;
      cfg_r.position_kp   <= cpmp_pkg::POSITION_KP_RST;
      cfg_r.position_kd   <= cpmp_pkg::POSITION_KD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer: walks one tick through distance update, position PD (both in position
  // mode; PD skipped while far), error, integral and the three speed-loop products,
  // then drops the result into the output register once the previous beat has been taken.
  cpmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .pos_mode  (cfg_r.position_mode),
    .far       (far),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Datapath: loop state, shared multiplier, accumulator, truncation toward
  // zero, drive limit and PWM compare mapping, plus the output register.
  cpmp_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg                 (cfg_r),
    .dist_load           (dist_load),
    .dist_value          (cfg_wdata),
    .in_encoder_count    (in_encoder_count),
    .far                 (far),
    .out_compare_a       (out_compare_a),
    .out_compare_b       (out_compare_b),
    .out_drive_value     (out_drive_value),
    .out_speed_goal_used (out_speed_goal_used)
  );

endmodule
